### hw/rtl/ps2mct_pkg.sv
// Shared types, constants and the clamp function of the PS/2 mouse cursor tracker.
package ps2mct_pkg;

	localparam int CoordBits = 12;
	localparam int BoundBits = 13;
	localparam int ByteBits  = 8;
	localparam int BtnBits   = 3;
	localparam int CountBits = 32;
	localparam int InXYBits  = 12;
	localparam int SumBits   = CoordBits + 2;
	localparam int ExtBits   = ((BoundBits > CoordBits) ? BoundBits : CoordBits) + 1;

	typedef logic [CoordBits-1:0] coord_t;
	typedef logic [BoundBits-1:0] bound_t;

	localparam coord_t CoordMax = {CoordBits{1'b1}};

	localparam bound_t WidthReset  = BoundBits'(640);
	localparam bound_t HeightReset = BoundBits'(480);
	localparam coord_t PosXReset   = CoordBits'(320);
	localparam coord_t PosYReset   = CoordBits'(240);

	// Configuration register indexes
	typedef enum logic {
		REG_SCREEN_WIDTH  = 1'b0,
		REG_SCREEN_HEIGHT = 1'b1
	} reg_idx_t;

	// Byte position inside a three-byte packet
	typedef enum logic [1:0] {
		PH_FLAGS = 2'd0,
		PH_XDATA = 2'd1,
		PH_YDATA = 2'd2
	} phase_t;

	typedef enum logic {
		FUNC_RX_BYTE  = 1'b0,
		FUNC_SET_POS  = 1'b1
	} func_t;

	// Flag byte bits
	localparam int FlagSync  = 3;
	localparam int FlagXSign = 4;
	localparam int FlagYSign = 5;
	localparam int FlagXOvf  = 6;
	localparam int FlagYOvf  = 7;

	// Clamp a moved coordinate to [0, bound-1], with a zero bound pinning to 0
	// and bounds past the coordinate range saturating at its maximum.
	function automatic coord_t clamp_axis(input logic signed [SumBits-1:0] v,
			input bound_t bound);
		bound_t               bm1;
		logic [ExtBits-1:0]   bm1_ext;
		coord_t               top;
		logic signed [SumBits-1:0] top_s;
		bm1     = bound - BoundBits'(1);
		bm1_ext = ExtBits'(bm1);
		if (bound == '0) begin
			top = '0;
		end else if (bm1_ext > ExtBits'(CoordMax)) begin
			top = CoordMax;
		end else begin
			top = CoordBits'(bm1_ext);
		end
		top_s = $signed({2'b00, top});
		if (v < 0) begin
			return '0;
		end else if (v > top_s) begin
			return top;
		end else begin
			return CoordBits'(v);
		end
	endfunction

endpackage

### hw/rtl/ps2mct_in_if.sv
// Input channel: one received byte or one set-position command per transaction.
interface ps2mct_in_if;
	logic                               valid;
	logic                               ready;
	logic                               func;
	logic                               from_mouse;
	logic [ps2mct_pkg::ByteBits-1:0]    data_byte;
	logic [ps2mct_pkg::InXYBits-1:0]    new_x;
	logic [ps2mct_pkg::InXYBits-1:0]    new_y;

	modport source (output valid, func, from_mouse, data_byte, new_x, new_y, input ready);
	modport sink   (input valid, func, from_mouse, data_byte, new_x, new_y, output ready);
endinterface

### hw/rtl/ps2mct_out_if.sv
// Result channel: cursor state reported after each input transaction.
interface ps2mct_out_if;
	logic                               valid;
	logic                               ready;
	logic [ps2mct_pkg::CoordBits-1:0]   cursor_x;
	logic [ps2mct_pkg::CoordBits-1:0]   cursor_y;
	logic [ps2mct_pkg::BtnBits-1:0]     button_bits;
	logic                               packet_done;
	logic [ps2mct_pkg::CountBits-1:0]   event_count;

	modport source (output valid, cursor_x, cursor_y, button_bits, packet_done, event_count,
		input ready);
	modport sink   (input valid, cursor_x, cursor_y, button_bits, packet_done, event_count,
		output ready);
endinterface

### hw/rtl/ps2_mouse_packet_cursor_tracker.sv
// Top level of the PS/2 mouse packet decoder and cursor tracker.
//
// Frames auxiliary-port bytes into three-byte PS/2 mouse packets and keeps a
// clamped cursor position, the latched buttons and a 32-bit count of accepted
// packets. Every input transaction yields exactly one result transaction that
// reports the state after that item. A packet starts only on a byte with the
// sync bit (bit 3) set; bytes without from_mouse are ignored; a packet with
// either overflow bit set is dropped. A set-position command (func 1) loads
// the cursor unclamped and leaves packet framing alone. Timing: an item is
// captured in the input register; when the result register is free or being
// taken, the framing and add-and-clamp logic runs and writes the state and the
// result register together, giving one item per cycle while results are taken.
// The one-item input register and the result register let a new item be taken
// while a finished result waits; ready drops only when both hold an item and
// the result is not being taken. Screen bounds reset to 640 x 480 and are written
// through cfg_we / cfg_idx / cfg_wdata; the user must do so only while the block
// is idle, unenforced by the block; bound changes do not re-clamp the cursor.
module ps2_mouse_packet_cursor_tracker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic                              cfg_idx,
	input  logic [ps2mct_pkg::BoundBits-1:0]  cfg_wdata,
	ps2mct_in_if.sink                         req,
	ps2mct_out_if.source                      rsp
);

	// Configuration
	ps2mct_pkg::bound_t screen_width_q;
	ps2mct_pkg::bound_t screen_height_q;

	// Input register
	logic                                valid_s1;
	logic                                func_s1;
	logic                                from_mouse_s1;
	logic [ps2mct_pkg::ByteBits-1:0]     data_byte_s1;
	logic [ps2mct_pkg::InXYBits-1:0]     new_x_s1;
	logic [ps2mct_pkg::InXYBits-1:0]     new_y_s1;

	// Tracker state
	ps2mct_pkg::phase_t                  phase_q;
	ps2mct_pkg::phase_t                  phase_nxt;
	logic [ps2mct_pkg::ByteBits-1:0]     flags_q;
	logic [ps2mct_pkg::ByteBits-1:0]     xbyte_q;
	ps2mct_pkg::coord_t                  pos_x_q;
	ps2mct_pkg::coord_t                  pos_y_q;
	logic [ps2mct_pkg::BtnBits-1:0]      buttons_q;
	logic [ps2mct_pkg::CountBits-1:0]    count_q;

	// Next-state values
	logic                                flags_ld;
	logic                                xbyte_ld;
	logic                                pkt_ok;
	ps2mct_pkg::coord_t                  pos_x_nxt;
	ps2mct_pkg::coord_t                  pos_y_nxt;
	logic [ps2mct_pkg::BtnBits-1:0]      buttons_nxt;
	logic [ps2mct_pkg::CountBits-1:0]    count_nxt;

	// Movement arithmetic
	logic signed [8:0]                   dx;
	logic signed [8:0]                   dy;
	logic signed [ps2mct_pkg::SumBits-1:0] sum_x;
	logic signed [ps2mct_pkg::SumBits-1:0] sum_y;

	// Result register
	logic                                valid_s2;
	logic                                done_s2;

	logic                                advance;
	logic                                mouse_byte;

	// Advance the input register into the result register when the result
	// slot is empty or its content is being taken this cycle.
	assign advance    = valid_s1 && (!valid_s2 || rsp.ready);
	assign req.ready  = !valid_s1 || advance;
	assign mouse_byte = (func_s1 == ps2mct_pkg::FUNC_RX_BYTE) && from_mouse_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			screen_width_q  <= ps2mct_pkg::WidthReset;
			screen_height_q <= ps2mct_pkg::HeightReset;
		end else if (cfg_we) begin
			case (cfg_idx)
				ps2mct_pkg::REG_SCREEN_WIDTH:  screen_width_q  <= cfg_wdata;
				ps2mct_pkg::REG_SCREEN_HEIGHT: screen_height_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Capture the incoming transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			func_s1       <= req.func;
			from_mouse_s1 <= req.from_mouse;
			data_byte_s1  <= req.data_byte;
			new_x_s1      <= req.new_x;
			new_y_s1      <= req.new_y;
		end
	end

	// Packet framing: next phase
	always_comb begin
		phase_nxt = phase_q;
		if (mouse_byte) begin
			case (phase_q)
				ps2mct_pkg::PH_XDATA: phase_nxt = ps2mct_pkg::PH_YDATA;
				ps2mct_pkg::PH_YDATA: phase_nxt = ps2mct_pkg::PH_FLAGS;
				default: begin
					// hunt for a sync byte; the unused code behaves as the flags phase
					if (data_byte_s1[ps2mct_pkg::FlagSync]) begin
						phase_nxt = ps2mct_pkg::PH_XDATA;
					end else begin
						phase_nxt = ps2mct_pkg::PH_FLAGS;
					end
				end
			endcase
		end
	end

	// Packet framing: load strobes
	always_comb begin
		flags_ld = 1'b0;
		xbyte_ld = 1'b0;
		pkt_ok   = 1'b0;
		if (mouse_byte) begin
			case (phase_q)
				ps2mct_pkg::PH_XDATA: xbyte_ld = 1'b1;
				ps2mct_pkg::PH_YDATA: pkt_ok = !flags_q[ps2mct_pkg::FlagXOvf] &&
					!flags_q[ps2mct_pkg::FlagYOvf];
				default: flags_ld = data_byte_s1[ps2mct_pkg::FlagSync];
			endcase
		end
	end

	// 9-bit two's-complement deltas; screen Y grows downward, so subtract dy
	assign dx    = $signed({flags_q[ps2mct_pkg::FlagXSign], xbyte_q});
	assign dy    = $signed({flags_q[ps2mct_pkg::FlagYSign], data_byte_s1});
	assign sum_x = $signed({2'b00, pos_x_q}) + ps2mct_pkg::SumBits'(dx);
	assign sum_y = $signed({2'b00, pos_y_q}) - ps2mct_pkg::SumBits'(dy);

	always_comb begin
		pos_x_nxt   = pos_x_q;
		pos_y_nxt   = pos_y_q;
		buttons_nxt = buttons_q;
		count_nxt   = count_q;
		if (func_s1 == ps2mct_pkg::FUNC_SET_POS) begin
			pos_x_nxt = ps2mct_pkg::CoordBits'(new_x_s1);
			pos_y_nxt = ps2mct_pkg::CoordBits'(new_y_s1);
		end else if (pkt_ok) begin
			pos_x_nxt   = ps2mct_pkg::clamp_axis(sum_x, screen_width_q);
			pos_y_nxt   = ps2mct_pkg::clamp_axis(sum_y, screen_height_q);
			buttons_nxt = flags_q[ps2mct_pkg::BtnBits-1:0];
			count_nxt   = count_q + ps2mct_pkg::CountBits'(1);
		end
	end

	// Commit state; the state registers double as the result payload
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= ps2mct_pkg::PH_FLAGS;
			flags_q   <= '0;
			xbyte_q   <= '0;
			pos_x_q   <= ps2mct_pkg::PosXReset;
			pos_y_q   <= ps2mct_pkg::PosYReset;
			buttons_q <= '0;
			count_q   <= '0;
			valid_s2  <= 1'b0;
			done_s2   <= 1'b0;
		end else begin
			if (advance) begin
				phase_q   <= phase_nxt;
				pos_x_q   <= pos_x_nxt;
				pos_y_q   <= pos_y_nxt;
				buttons_q <= buttons_nxt;
				count_q   <= count_nxt;
				done_s2   <= pkt_ok && (func_s1 == ps2mct_pkg::FUNC_RX_BYTE);
				if (flags_ld) begin
					flags_q <= data_byte_s1;
				end
				if (xbyte_ld) begin
					xbyte_q <= data_byte_s1;
				end
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (rsp.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	assign rsp.valid       = valid_s2;
	assign rsp.cursor_x    = pos_x_q;
	assign rsp.cursor_y    = pos_y_q;
	assign rsp.button_bits = buttons_q;
	assign rsp.packet_done = done_s2;
	assign rsp.event_count = count_q;

`ifndef ASSERT_OFF
	// The packet count moves exactly when the committed item completed a packet
	a_count_tracks_done: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> (done_s2 == (count_q != $past(count_q))))
		else $error("event count and packet_done disagree");

	// Hold the reported cursor while a result is stalled
	a_stall_holds_state: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !rsp.ready) |=> ($stable(pos_x_q) && $stable(pos_y_q) &&
			$stable(count_q)))
		else $error("tracker state changed under a stalled result");

	// A completed packet always leaves framing back at the flags phase
	a_done_resyncs: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && pkt_ok) |=> (phase_q == ps2mct_pkg::PH_FLAGS))
		else $error("framing not reset after packet");
`endif

endmodule
